@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define HAX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define HAX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/hax_pkg.sv @@
// ----------------------------------------------------------------------------
// hax_pkg
// Types and constants shared by the hex anode position pipeline.
// ----------------------------------------------------------------------------
package hax_pkg;

  localparam int TIME_W    = 32;
  localparam int XY_W      = 22;
  // intermediate coordinate width ahead of the divide by three
  localparam int MID_W     = 24;
  localparam int DIV_W     = 25;
  localparam int DIV_SHIFT = 26;
  localparam int PROD_W    = 50;

  localparam logic [1:0] SEL_ELECTRON = 2'd0;
  localparam logic [1:0] SEL_POSITRON = 2'd1;
  localparam logic [1:0] SEL_BOTH     = 2'd2;

  localparam logic SIDE_ELECTRON = 1'b0;
  localparam logic SIDE_POSITRON = 1'b1;

  localparam logic [1:0] PAIRS_NONE  = 2'd0;
  localparam logic [1:0] PAIRS_ONE   = 2'd1;
  localparam logic [1:0] PAIRS_TWO   = 2'd2;
  localparam logic [1:0] PAIRS_THREE = 2'd3;

  // round(2^16 / sqrt(3))
  localparam logic signed [16:0] INV_SQRT3_Q16 = 17'sd37837;

  // floor(b / 3) == (b * DIV3_MAGIC) >> DIV_SHIFT, exact for b < 2^DIV_W
  localparam logic [DIV_W-1:0]       DIV3_MAGIC  = 25'd22369622;
  // 3 * 2^23 keeps the dividend positive; divides out to DIV3_BIAS
  localparam logic signed [MID_W+1:0] DIV3_OFFSET = 26'sd25165824;
  localparam logic [MID_W-1:0]       DIV3_BIAS   = 24'd8388608;

  // clamp bounds: three times the output range, so saturation stays exact
  localparam logic signed [MID_W-1:0] MID_MAX = 24'sd6291455;
  localparam logic signed [MID_W-1:0] MID_MIN = -24'sd6291456;

  localparam logic signed [XY_W-1:0] XY_MAX = 22'sd2097151;
  localparam logic signed [XY_W-1:0] XY_MIN = -22'sd2097152;

  typedef struct packed {
    logic              side;
    logic [TIME_W-1:0] hit_time;
    logic              used_uv;
    logic              used_uw;
    logic              used_vw;
    logic              valid_res;
    logic [1:0]        pairs;
  } meta_t;

endpackage

@@ sv/hax_pair_sum.sv @@
// ----------------------------------------------------------------------------
// hax_pair_sum
// Input stage: detector filter, pair selection and x / y difference sums.
// ----------------------------------------------------------------------------
module hax_pair_sum #(
  parameter int COORD_WIDTH = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  logic [1:0]                    detector_select_i,
  input  logic                          side_i,
  input  logic signed [COORD_WIDTH-1:0] u_pos_i,
  input  logic signed [COORD_WIDTH-1:0] v_pos_i,
  input  logic signed [COORD_WIDTH-1:0] w_pos_i,
  input  logic                          u_single_i,
  input  logic                          v_single_i,
  input  logic                          w_single_i,
  input  logic [hax_pkg::TIME_W-1:0]    hit_time_i,
  output logic                          valid_o,
  output hax_pkg::meta_t                meta_o,
  output logic signed [COORD_WIDTH+2:0] sx_o,
  output logic signed [COORD_WIDTH+3:0] sd_o
);

  localparam int SXW = COORD_WIDTH + 3;
  localparam int SDW = COORD_WIDTH + 4;

  logic signed [SDW-1:0] u_e, v_e, w_e;
  logic signed [SDW-1:0] sx_d, sd_d;
  logic                  take_uv, take_uw, take_vw;
  logic                  use_uv, use_uw, use_vw;
  logic                  sel_ok;
  hax_pkg::meta_t        meta_d;

  logic                  valid_q;
  hax_pkg::meta_t        meta_q;
  logic signed [SXW-1:0] sx_q;
  logic signed [SDW-1:0] sd_q;

  assign u_e = SDW'(u_pos_i);
  assign v_e = SDW'(v_pos_i);
  assign w_e = SDW'(w_pos_i);

  always_comb begin
    take_uv = u_single_i & v_single_i;
    take_uw = u_single_i & w_single_i;
    take_vw = v_single_i & w_single_i;

    if (side_i == hax_pkg::SIDE_POSITRON) begin
      sel_ok = (detector_select_i == hax_pkg::SEL_POSITRON) ||
               (detector_select_i == hax_pkg::SEL_BOTH);
      // positron: first usable pair only, order UV, UW, VW
      use_uv = take_uv;
      use_uw = take_uw & ~take_uv;
      use_vw = take_vw & ~take_uv & ~take_uw;
      if (take_uv) begin
        sx_d = -u_e;
        sd_d = u_e - (v_e + v_e);
      end else if (take_uw) begin
        sx_d = -u_e;
        sd_d = (w_e + w_e) + u_e;
      end else if (take_vw) begin
        sx_d = -v_e - w_e;
        sd_d = w_e - v_e;
      end else begin
        sx_d = '0;
        sd_d = '0;
      end
    end else begin
      sel_ok = (detector_select_i == hax_pkg::SEL_ELECTRON) ||
               (detector_select_i == hax_pkg::SEL_BOTH);
      // electron: every usable pair is summed
      use_uv = take_uv;
      use_uw = take_uw;
      use_vw = take_vw;
      sx_d = (take_uv ? u_e : '0) + (take_uw ? u_e : '0) + (take_vw ? (v_e - w_e) : '0);
      sd_d = (take_uv ? ((v_e + v_e) - u_e) : '0) +
             (take_uw ? ((w_e + w_e) + u_e) : '0) +
             (take_vw ? (w_e + v_e) : '0);
    end

    meta_d.side      = side_i;
    meta_d.hit_time  = hit_time_i;
    meta_d.used_uv   = use_uv;
    meta_d.used_uw   = use_uw;
    meta_d.used_vw   = use_vw;
    meta_d.valid_res = use_uv | use_uw | use_vw;
    meta_d.pairs     = 2'({1'b0, use_uv} + {1'b0, use_uw} + {1'b0, use_vw});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      // filtered hits are dropped here
      valid_q <= in_valid_i & sel_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q <= meta_d;
      sx_q   <= SXW'(sx_d);
      sd_q   <= sd_d;
    end
  end

  assign valid_o = valid_q;
  assign meta_o  = meta_q;
  assign sx_o    = sx_q;
  assign sd_o    = sd_q;

endmodule

@@ sv/hax_scale.sv @@
// ----------------------------------------------------------------------------
// hax_scale
// 1/sqrt(3) multiply, then rounding by pair count and clamp to the
// intermediate width. Two register stages.
// ----------------------------------------------------------------------------
module hax_scale #(
  parameter int COORD_WIDTH = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  hax_pkg::meta_t                      meta_i,
  input  logic signed [COORD_WIDTH+2:0]       sx_i,
  input  logic signed [COORD_WIDTH+3:0]       sd_i,
  output logic                                valid_o,
  output hax_pkg::meta_t                      meta_o,
  output logic signed [hax_pkg::MID_W-1:0]    ax_o,
  output logic signed [hax_pkg::MID_W-1:0]    ay_o,
  output logic                                div3_o
);

  localparam int SXW = COORD_WIDTH + 3;
  localparam int PW  = COORD_WIDTH + 21;
  localparam int PEW = PW + 1;

  function automatic logic signed [hax_pkg::MID_W-1:0] clamp_mid(
    input logic signed [PEW-1:0] v
  );
    logic signed [hax_pkg::MID_W-1:0] r;
    if (v > PEW'(hax_pkg::MID_MAX)) begin
      r = hax_pkg::MID_MAX;
    end else if (v < PEW'(hax_pkg::MID_MIN)) begin
      r = hax_pkg::MID_MIN;
    end else begin
      r = hax_pkg::MID_W'(v);
    end
    return r;
  endfunction

  // stage 2
  logic                  v2_q;
  hax_pkg::meta_t        meta2_q;
  logic signed [SXW-1:0] sx2_q;
  logic signed [PW-1:0]  p2_q;
  logic signed [PW-1:0]  p_d;

  assign p_d = PW'(sd_i) * PW'(hax_pkg::INV_SQRT3_Q16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta2_q <= meta_i;
      sx2_q   <= sx_i;
      p2_q    <= p_d;
    end
  end

  // stage 3: round to nearest, ties up; a divide by three remains for n = 3
  logic signed [PEW-1:0] xe, pe, rnd, xv, yv;

  always_comb begin
    xe = PEW'(sx2_q);
    case (meta2_q.pairs)
      hax_pkg::PAIRS_TWO:   rnd = PEW'(32'sd65536);
      hax_pkg::PAIRS_THREE: rnd = PEW'(32'sd98304);
      default:              rnd = PEW'(32'sd32768);
    endcase
    pe = PEW'(p2_q) + rnd;
    case (meta2_q.pairs)
      hax_pkg::PAIRS_ONE: begin
        xv = xe;
        yv = pe >>> 16;
      end
      hax_pkg::PAIRS_TWO: begin
        xv = (xe + PEW'(1)) >>> 1;
        yv = pe >>> 17;
      end
      hax_pkg::PAIRS_THREE: begin
        xv = xe + PEW'(1);
        yv = pe >>> 16;
      end
      default: begin
        xv = '0;
        yv = '0;
      end
    endcase
  end

  logic                              v3_q;
  hax_pkg::meta_t                    meta3_q;
  logic signed [hax_pkg::MID_W-1:0]  ax3_q, ay3_q;
  logic                              div3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta3_q <= meta2_q;
      ax3_q   <= clamp_mid(xv);
      ay3_q   <= clamp_mid(yv);
      div3_q  <= (meta2_q.pairs == hax_pkg::PAIRS_THREE);
    end
  end

  assign valid_o = v3_q;
  assign meta_o  = meta3_q;
  assign ax_o    = ax3_q;
  assign ay_o    = ay3_q;
  assign div3_o  = div3_q;

endmodule

@@ sv/hax_div3.sv @@
// ----------------------------------------------------------------------------
// hax_div3
// Floor divide by three via reciprocal multiply for three-pair results,
// then saturation to the output range and the output register.
// ----------------------------------------------------------------------------
module hax_div3 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  hax_pkg::meta_t                    meta_i,
  input  logic signed [hax_pkg::MID_W-1:0]  ax_i,
  input  logic signed [hax_pkg::MID_W-1:0]  ay_i,
  input  logic                              div3_i,
  output logic                              valid_o,
  output hax_pkg::meta_t                    meta_o,
  output logic signed [hax_pkg::XY_W-1:0]   x_o,
  output logic signed [hax_pkg::XY_W-1:0]   y_o
);

  localparam int MID_W  = hax_pkg::MID_W;
  localparam int DIV_W  = hax_pkg::DIV_W;
  localparam int PROD_W = hax_pkg::PROD_W;
  localparam int XY_W   = hax_pkg::XY_W;

  function automatic logic signed [XY_W-1:0] sat_xy(input logic signed [MID_W-1:0] v);
    logic signed [XY_W-1:0] r;
    if (v > MID_W'(hax_pkg::XY_MAX)) begin
      r = hax_pkg::XY_MAX;
    end else if (v < MID_W'(hax_pkg::XY_MIN)) begin
      r = hax_pkg::XY_MIN;
    end else begin
      r = XY_W'(v);
    end
    return r;
  endfunction

  // stage 4: offset to a positive dividend and multiply
  logic signed [MID_W+1:0] tx, ty;
  logic [DIV_W-1:0]        bx, by;
  logic [PROD_W-1:0]       px_d, py_d;

  assign tx   = (MID_W+2)'(ax_i) + hax_pkg::DIV3_OFFSET;
  assign ty   = (MID_W+2)'(ay_i) + hax_pkg::DIV3_OFFSET;
  assign bx   = tx[DIV_W-1:0];
  assign by   = ty[DIV_W-1:0];
  assign px_d = PROD_W'(bx) * PROD_W'(hax_pkg::DIV3_MAGIC);
  assign py_d = PROD_W'(by) * PROD_W'(hax_pkg::DIV3_MAGIC);

  logic                    v4_q;
  hax_pkg::meta_t          meta4_q;
  logic signed [MID_W-1:0] ax4_q, ay4_q;
  logic                    div3_4_q;
  logic [PROD_W-1:0]       px4_q, py4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta4_q  <= meta_i;
      ax4_q    <= ax_i;
      ay4_q    <= ay_i;
      div3_4_q <= div3_i;
      px4_q    <= px_d;
      py4_q    <= py_d;
    end
  end

  // stage 5: remove the offset, pick the path, saturate
  logic [MID_W-1:0]        qx, qy;
  logic signed [MID_W-1:0] selx, sely;

  assign qx   = px4_q[PROD_W-1:hax_pkg::DIV_SHIFT] - hax_pkg::DIV3_BIAS;
  assign qy   = py4_q[PROD_W-1:hax_pkg::DIV_SHIFT] - hax_pkg::DIV3_BIAS;
  assign selx = div3_4_q ? $signed(qx) : ax4_q;
  assign sely = div3_4_q ? $signed(qy) : ay4_q;

  logic                   valid_q;
  hax_pkg::meta_t         meta_q;
  logic signed [XY_W-1:0] x_q, y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q <= meta4_q;
      x_q    <= sat_xy(selx);
      y_q    <= sat_xy(sely);
    end
  end

  assign valid_o = valid_q;
  assign meta_o  = meta_q;
  assign x_o     = x_q;
  assign y_o     = y_q;

endmodule

@@ sv/hex_anode_xy_reconstruction.sv @@
// ----------------------------------------------------------------------------
// hex_anode_xy_reconstruction
// Hexagonal delay-line anode hit to x / y position, five-stage pipeline.
// ----------------------------------------------------------------------------
// channel  | handshake                 | payload
// ---------+---------------------------+----------------------------------------
// in       | in_valid_i / in_ready_o   | side, u/v/w_pos, u/v/w_single, hit_time
// out      | out_valid_o / out_ready_i | out_side, x/y_pos, out_time, used_*, valid_res
// cfg      | cfg_we_i                  | cfg_wdata_i (detector_select)
//
// One item per cycle while the output is not stalled; the 1/sqrt(3) multiply and the
// reciprocal divide by three each own a stage.
// A stalled output freezes every stage; in_ready_o drops for that cycle.
// Reset clears the stage valid bits and sets detector_select to both.
// Hits filtered out by detector_select leave a bubble and no result.
// ----------------------------------------------------------------------------
module hex_anode_xy_reconstruction #(
  parameter int COORD_WIDTH = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               side_i,
  input  logic signed [COORD_WIDTH-1:0]      u_pos_i,
  input  logic signed [COORD_WIDTH-1:0]      v_pos_i,
  input  logic signed [COORD_WIDTH-1:0]      w_pos_i,
  input  logic                               u_single_i,
  input  logic                               v_single_i,
  input  logic                               w_single_i,
  input  logic signed [hax_pkg::TIME_W-1:0]  hit_time_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               out_side_o,
  output logic signed [hax_pkg::XY_W-1:0]    x_pos_o,
  output logic signed [hax_pkg::XY_W-1:0]    y_pos_o,
  output logic signed [hax_pkg::TIME_W-1:0]  out_time_o,
  output logic                               used_uv_o,
  output logic                               used_uw_o,
  output logic                               used_vw_o,
  output logic                               valid_res_o,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_wdata_i
);

  logic [1:0] detector_select_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detector_select_q <= hax_pkg::SEL_BOTH;
    end else if (cfg_we_i) begin
      detector_select_q <= cfg_wdata_i;
    end
  end

  logic en;
  assign en         = ~out_valid_o | out_ready_i;
  assign in_ready_o = en;

  logic                                s1_valid;
  hax_pkg::meta_t                      s1_meta;
  logic signed [COORD_WIDTH+2:0]       s1_sx;
  logic signed [COORD_WIDTH+3:0]       s1_sd;

  hax_pair_sum #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_pair_sum (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .in_valid_i        (in_valid_i),
    .detector_select_i (detector_select_q),
    .side_i            (side_i),
    .u_pos_i           (u_pos_i),
    .v_pos_i           (v_pos_i),
    .w_pos_i           (w_pos_i),
    .u_single_i        (u_single_i),
    .v_single_i        (v_single_i),
    .w_single_i        (w_single_i),
    .hit_time_i        (hit_time_i),
    .valid_o           (s1_valid),
    .meta_o            (s1_meta),
    .sx_o              (s1_sx),
    .sd_o              (s1_sd)
  );

  logic                                s3_valid;
  hax_pkg::meta_t                      s3_meta;
  logic signed [hax_pkg::MID_W-1:0]    s3_ax, s3_ay;
  logic                                s3_div3;

  hax_scale #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid),
    .meta_i  (s1_meta),
    .sx_i    (s1_sx),
    .sd_i    (s1_sd),
    .valid_o (s3_valid),
    .meta_o  (s3_meta),
    .ax_o    (s3_ax),
    .ay_o    (s3_ay),
    .div3_o  (s3_div3)
  );

  hax_pkg::meta_t out_meta;

  hax_div3 u_div3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_valid),
    .meta_i  (s3_meta),
    .ax_i    (s3_ax),
    .ay_i    (s3_ay),
    .div3_i  (s3_div3),
    .valid_o (out_valid_o),
    .meta_o  (out_meta),
    .x_o     (x_pos_o),
    .y_o     (y_pos_o)
  );

  assign out_side_o  = out_meta.side;
  assign out_time_o  = $signed(out_meta.hit_time);
  assign used_uv_o   = out_meta.used_uv;
  assign used_uw_o   = out_meta.used_uw;
  assign used_vw_o   = out_meta.used_vw;
  assign valid_res_o = out_meta.valid_res;

endmodule

@@ sv/hax_port_checker.sv @@
// ----------------------------------------------------------------------------
// hax_port_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hax_port_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic                               out_side_o,
  input logic signed [hax_pkg::XY_W-1:0]    x_pos_o,
  input logic signed [hax_pkg::XY_W-1:0]    y_pos_o,
  input logic signed [hax_pkg::TIME_W-1:0]  out_time_o,
  input logic                               used_uv_o,
  input logic                               used_uw_o,
  input logic                               used_vw_o,
  input logic                               valid_res_o
);

  logic                                        out_stall;
  logic                                        pos_hit;
  logic                                        xy_zero;
  logic [2:0]                                  used_flags;
  logic [2*hax_pkg::XY_W+hax_pkg::TIME_W-1:0]  out_word;

  assign out_stall  = out_valid_o && !out_ready_i;
  assign pos_hit    = out_valid_o && (out_side_o == hax_pkg::SIDE_POSITRON);
  assign xy_zero    = (x_pos_o == '0) && (y_pos_o == '0);
  assign used_flags = {used_uv_o, used_uw_o, used_vw_o};
  assign out_word   = {x_pos_o, y_pos_o, out_time_o};

  // a stalled result stays offered
  `HAX_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o)

  // and keeps its coordinates
  `HAX_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(out_word))

  // valid_res tracks the used pair flags
  `HAX_ASSERT_NOW(a_res_flags, clk_i, rst_ni, out_valid_o, valid_res_o == (|used_flags))

  // no usable pair gives a zero position
  `HAX_ASSERT_NOW(a_res_zero, clk_i, rst_ni, out_valid_o && !valid_res_o, xy_zero)

  // positron hits take a single pair at most
  `HAX_ASSERT_NOW(a_pos_single, clk_i, rst_ni, pos_hit, $onehot0(used_flags))

endmodule

bind hex_anode_xy_reconstruction hax_port_checker u_port_checker (.*);
